### sv/qmm_pkg.sv
package qmm_pkg;

	localparam int SW_W     = 2;
	localparam int STICK_W  = 7;
	localparam int ROLL_W   = 11;
	localparam int MOTOR_W  = 15;
	localparam int IDLE_W   = 15;
	localparam int MIN_W    = 11;
	localparam int BASE_W   = 12;
	localparam int GAIN_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	// Thrust is at most 4095 + 63 * 127, mixed values stay within 15 bits signed.
	localparam int THRUST_W = 14;
	localparam int MIX_W    = 15;
	localparam int HALF_W   = 10;
	localparam int PROD_W   = THRUST_W + MIN_W;
	localparam int DIV_STEPS = MOTOR_W;
	localparam int DIV_CNT_W = 4;

	localparam logic [SW_W-1:0] SW_UP   = 2'd0;
	localparam logic [SW_W-1:0] SW_MID  = 2'd1;
	localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
	localparam logic [SW_W-1:0] SW_HOLD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_PWM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRUST_BASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN = 2'd3;

	localparam logic [IDLE_W-1:0]  RST_IDLE_PWM    = 15'd1000;
	localparam logic [MIN_W-1:0]   RST_MIN_PWM     = 11'd1100;
	localparam logic [BASE_W-1:0]  RST_THRUST_BASE = 12'd1100;
	localparam logic [GAIN_W-1:0]  RST_THRUST_GAIN = 6'd10;
	localparam logic [MOTOR_W-1:0] RST_COMPARE     = 15'd1000;

	localparam logic signed [MIX_W-1:0] START_LOWEST = 15'sd2000;
	localparam logic [MOTOR_W-1:0] SAT_MAX = 15'h7fff;

	typedef struct packed {
		logic load_in;
		logic mix;
		logic eval;
		logic mul;
		logic div_load;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic rescale;
	} status_t;

endpackage

### sv/quad_motor_mixer_rescale.sv
// The result transfer is offered once the input has passed the mix, evaluate and done states;
// when proportional rescaling runs, the multiply, load and divide states follow before done
// commits (two parallel 15-step restoring dividers). A new item is taken while the previous
// result still waits on the output.
// Reset (arst_n low, asynchronous): registers go to their defaults, all held compare values to
// 1000, no result pending.
module quad_motor_mixer_rescale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // stick_thrust[6:0], roll_correction[17:7], zero fill
	input  logic [1:0]  s_tuser,   // switch_pos[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // motor_one[14:0], motor_two[29:15], motor_three[44:30],
	                               // motor_four[59:45], zero fill
	output logic [1:0]  m_tuser,   // rescaled[0], fault[1]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	qmm_pkg::cmd_t    cmd;
	qmm_pkg::status_t status;

	logic [qmm_pkg::MOTOR_W-1:0] motor_one;
	logic [qmm_pkg::MOTOR_W-1:0] motor_two;
	logic [qmm_pkg::MOTOR_W-1:0] motor_three;
	logic [qmm_pkg::MOTOR_W-1:0] motor_four;
	logic                        rescaled;
	logic                        fault;

	qmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	qmm_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.switch_pos      (s_tuser),
		.stick_thrust    (s_tdata[6:0]),
		.roll_correction (s_tdata[17:7]),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.motor_one       (motor_one),
		.motor_two       (motor_two),
		.motor_three     (motor_three),
		.motor_four      (motor_four),
		.rescaled        (rescaled),
		.fault           (fault)
	);

	assign m_tdata = {4'b0000, motor_four, motor_three, motor_two, motor_one};
	assign m_tuser = {fault, rescaled};

endmodule

### sv/qmm_div_lane.sv
module qmm_div_lane (
	input  logic                             clk,
	input  logic                             load,
	input  logic                             step,
	input  logic [qmm_pkg::PROD_W-1:0]       dividend,
	input  logic [qmm_pkg::MIN_W-1:0]        divisor,
	output logic [qmm_pkg::MOTOR_W-1:0]      quot
);

	logic [qmm_pkg::MIN_W-1:0]   rem_q;
	logic [qmm_pkg::MOTOR_W-1:0] low_q;
	logic                        ovf_q;
	logic [qmm_pkg::MIN_W:0]     trial;
	logic [qmm_pkg::MIN_W:0]     diff;
	logic                        ge;

	assign trial = {rem_q, low_q[qmm_pkg::MOTOR_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// The quotient overflows 15 bits exactly when the upper dividend bits reach the divisor.
	always_ff @(posedge clk) begin
		if (load) begin
			ovf_q <= {1'b0, dividend[qmm_pkg::PROD_W-1:qmm_pkg::MOTOR_W]} >= divisor;
			rem_q <= {1'b0, dividend[qmm_pkg::PROD_W-1:qmm_pkg::MOTOR_W]};
			low_q <= dividend[qmm_pkg::MOTOR_W-1:0];
		end else if (step) begin
			rem_q <= ge ? diff[qmm_pkg::MIN_W-1:0] : trial[qmm_pkg::MIN_W-1:0];
			low_q <= {low_q[qmm_pkg::MOTOR_W-2:0], ge};
		end
	end

	assign quot = ovf_q ? qmm_pkg::SAT_MAX : low_q;

endmodule

### sv/qmm_datapath.sv
module qmm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qmm_pkg::cmd_t                       cmd,
	output qmm_pkg::status_t                    status,
	input  logic [qmm_pkg::SW_W-1:0]            switch_pos,
	input  logic [qmm_pkg::STICK_W-1:0]         stick_thrust,
	input  logic signed [qmm_pkg::ROLL_W-1:0]   roll_correction,
	input  logic                                cfg_we,
	input  logic [qmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qmm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [qmm_pkg::MOTOR_W-1:0]         motor_one,
	output logic [qmm_pkg::MOTOR_W-1:0]         motor_two,
	output logic [qmm_pkg::MOTOR_W-1:0]         motor_three,
	output logic [qmm_pkg::MOTOR_W-1:0]         motor_four,
	output logic                                rescaled,
	output logic                                fault
);

	logic [qmm_pkg::IDLE_W-1:0] idle_q;
	logic [qmm_pkg::MIN_W-1:0]  min_q;
	logic [qmm_pkg::BASE_W-1:0] base_q;
	logic [qmm_pkg::GAIN_W-1:0] gain_q;

	logic [qmm_pkg::SW_W-1:0]          sw_q;
	logic [qmm_pkg::STICK_W-1:0]       stick_q;
	logic signed [qmm_pkg::ROLL_W-1:0] roll_q;

	logic signed [qmm_pkg::MIX_W-1:0] mix_a_q;
	logic signed [qmm_pkg::MIX_W-1:0] mix_b_q;
	logic [qmm_pkg::MIN_W-1:0]        lowest_q;
	logic                             fault_q;
	logic                             rescale_q;
	logic [qmm_pkg::PROD_W-1:0]       prod_a_q;
	logic [qmm_pkg::PROD_W-1:0]       prod_b_q;

	logic [qmm_pkg::MOTOR_W-1:0] held_q [4];
	logic                        out_rescaled_q;
	logic                        out_fault_q;

	logic [qmm_pkg::STICK_W+qmm_pkg::GAIN_W-1:0] thrust_prod;
	logic [qmm_pkg::THRUST_W-1:0]                thrust;
	logic [qmm_pkg::ROLL_W-1:0]                  roll_adj;
	logic [qmm_pkg::HALF_W-1:0]                  half;
	logic signed [qmm_pkg::MIX_W-1:0]            half_ext;
	logic signed [qmm_pkg::MIX_W-1:0]            thrust_ext;
	logic signed [qmm_pkg::MIX_W-1:0]            low_ab;
	logic signed [qmm_pkg::MIX_W-1:0]            lowest;
	logic signed [qmm_pkg::MIX_W-1:0]            min_ext;
	logic [qmm_pkg::MOTOR_W-1:0]                 quot_a;
	logic [qmm_pkg::MOTOR_W-1:0]                 quot_b;
	logic [qmm_pkg::MOTOR_W-1:0]                 new_a;
	logic [qmm_pkg::MOTOR_W-1:0]                 new_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= qmm_pkg::RST_IDLE_PWM;
			min_q  <= qmm_pkg::RST_MIN_PWM;
			base_q <= qmm_pkg::RST_THRUST_BASE;
			gain_q <= qmm_pkg::RST_THRUST_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				qmm_pkg::REG_IDLE_PWM:    idle_q <= cfg_data[qmm_pkg::IDLE_W-1:0];
				qmm_pkg::REG_MIN_PWM:     min_q  <= cfg_data[qmm_pkg::MIN_W-1:0];
				qmm_pkg::REG_THRUST_BASE: base_q <= cfg_data[qmm_pkg::BASE_W-1:0];
				qmm_pkg::REG_THRUST_GAIN: gain_q <= cfg_data[qmm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Mixing: half the roll, rounded toward zero by adding one before the shift when negative.
	assign thrust_prod = gain_q * stick_q;
	assign thrust      = {2'b00, base_q} + {1'b0, thrust_prod};
	assign roll_adj    = roll_q + {{(qmm_pkg::ROLL_W-1){1'b0}}, roll_q[qmm_pkg::ROLL_W-1]};
	assign half        = roll_adj[qmm_pkg::ROLL_W-1:1];
	assign half_ext    = {{(qmm_pkg::MIX_W-qmm_pkg::HALF_W){half[qmm_pkg::HALF_W-1]}}, half};
	assign thrust_ext  = {1'b0, thrust};

	assign low_ab  = (mix_a_q < mix_b_q) ? mix_a_q : mix_b_q;
	assign lowest  = (low_ab < qmm_pkg::START_LOWEST) ? low_ab : qmm_pkg::START_LOWEST;
	assign min_ext = {4'b0000, min_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sw_q    <= switch_pos;
			stick_q <= stick_thrust;
			roll_q  <= roll_correction;
		end
		if (cmd.mix) begin
			mix_a_q <= thrust_ext - half_ext;
			mix_b_q <= thrust_ext + half_ext;
		end
		if (cmd.eval) begin
			lowest_q  <= lowest[qmm_pkg::MIN_W-1:0];
			fault_q   <= (sw_q == qmm_pkg::SW_DOWN) && (lowest <= 0);
			rescale_q <= (sw_q == qmm_pkg::SW_DOWN) && (lowest > 0) && (lowest < min_ext);
		end
		if (cmd.mul) begin
			prod_a_q <= qmm_pkg::PROD_W'(mix_a_q[qmm_pkg::THRUST_W-1:0]) *
				qmm_pkg::PROD_W'(min_q);
			prod_b_q <= qmm_pkg::PROD_W'(mix_b_q[qmm_pkg::THRUST_W-1:0]) *
				qmm_pkg::PROD_W'(min_q);
		end
	end

	qmm_div_lane u_div_a (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (prod_a_q),
		.divisor  (lowest_q),
		.quot     (quot_a)
	);

	qmm_div_lane u_div_b (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (prod_b_q),
		.divisor  (lowest_q),
		.quot     (quot_b)
	);

	always_comb begin
		if (fault_q) begin
			new_a = {4'b0000, min_q};
			new_b = {4'b0000, min_q};
		end else if (rescale_q) begin
			new_a = quot_a;
			new_b = quot_b;
		end else begin
			new_a = mix_a_q[qmm_pkg::MOTOR_W-1:0];
			new_b = mix_b_q[qmm_pkg::MOTOR_W-1:0];
		end
	end

	// The held compare values double as the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= qmm_pkg::RST_COMPARE;
			end
		end else if (cmd.commit) begin
			case (sw_q)
				qmm_pkg::SW_UP, qmm_pkg::SW_MID: begin
					for (int i = 0; i < 4; i++) begin
						held_q[i] <= idle_q;
					end
				end
				qmm_pkg::SW_DOWN: begin
					held_q[0] <= new_a;
					held_q[1] <= new_a;
					held_q[2] <= new_b;
					held_q[3] <= new_b;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_rescaled_q <= rescale_q;
			out_fault_q    <= fault_q;
		end
	end

	assign status.rescale = rescale_q;

	assign motor_one   = held_q[0];
	assign motor_two   = held_q[1];
	assign motor_three = held_q[2];
	assign motor_four  = held_q[3];
	assign rescaled    = out_rescaled_q;
	assign fault       = out_fault_q;

endmodule

### sv/qmm_ctrl.sv
module qmm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  qmm_pkg::status_t status,
	output qmm_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MIX  = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                      state_q;
	logic [2:0]                      state_d;
	logic [qmm_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            out_valid_q;
	logic                            slot_free;
	logic                            last_step;

	assign slot_free = !out_valid_q || out_ready;
	assign last_step = cnt_q == qmm_pkg::DIV_CNT_W'(qmm_pkg::DIV_STEPS - 1);
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_MIX;
				end
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_DONE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// A mix that needs rescaling is routed through the dividers before the commit.
				if (status.rescale && cnt_q == '0) begin
					state_d = S_MUL;
				end else begin
					cmd.commit = slot_free;
					if (slot_free) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= last_step ? cnt_q : cnt_q + 1'b1;
			end else if (state_q == S_IDLE) begin
				cnt_q <= '0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### tb/quad_motor_mixer_rescale_tb.sv
`timescale 1ns / 100ps

module quad_motor_mixer_rescale_tb;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int TICKS_PER_PHASE = 230;

	typedef struct packed {
		logic [3:0][qmm_pkg::MOTOR_W-1:0] motor;
		logic                             rescaled;
		logic                             fault;
	} motor_frame_t;

	class mixer_scoreboard;
		logic [qmm_pkg::IDLE_W-1:0]  idle_pwm;
		logic [qmm_pkg::MIN_W-1:0]   min_pwm;
		logic [qmm_pkg::BASE_W-1:0]  thrust_base;
		logic [qmm_pkg::GAIN_W-1:0]  thrust_gain;
		logic [qmm_pkg::MOTOR_W-1:0] held [4];
		motor_frame_t                expected_frames [$];
		int                          mismatches;

		function new();
			idle_pwm = qmm_pkg::RST_IDLE_PWM;
			min_pwm = qmm_pkg::RST_MIN_PWM;
			thrust_base = qmm_pkg::RST_THRUST_BASE;
			thrust_gain = qmm_pkg::RST_THRUST_GAIN;
			for (int i = 0; i < 4; i++)
				held[i] = qmm_pkg::RST_COMPARE;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void note_config(logic [qmm_pkg::CFG_IDX_W-1:0] idx,
				logic [qmm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				qmm_pkg::REG_IDLE_PWM:    idle_pwm = data[qmm_pkg::IDLE_W-1:0];
				qmm_pkg::REG_MIN_PWM:     min_pwm = data[qmm_pkg::MIN_W-1:0];
				qmm_pkg::REG_THRUST_BASE: thrust_base = data[qmm_pkg::BASE_W-1:0];
				qmm_pkg::REG_THRUST_GAIN: thrust_gain = data[qmm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [qmm_pkg::MOTOR_W-1:0] clamp_compare(longint v);
			if (v < 0)
				return '0;
			if (v > longint'(qmm_pkg::SAT_MAX))
				return qmm_pkg::SAT_MAX;
			return v[qmm_pkg::MOTOR_W-1:0];
		endfunction

		// Mixes one accepted control tick and queues the frame it must produce.
		function void note_tick(logic [qmm_pkg::SW_W-1:0] sw, logic [qmm_pkg::STICK_W-1:0] stick,
				logic [qmm_pkg::ROLL_W-1:0] roll_raw);
			int           thrust;
			int           half;
			int           lowest;
			int           mix [4];
			motor_frame_t frame;
			frame = '0;
			case (sw)
				qmm_pkg::SW_UP, qmm_pkg::SW_MID: begin
					for (int i = 0; i < 4; i++)
						held[i] = idle_pwm;
				end
				qmm_pkg::SW_DOWN: begin
					thrust = int'(thrust_base) + int'(thrust_gain) * int'(stick);
					// Integer division truncates toward zero, as the halving requires.
					half = int'($signed(roll_raw)) / 2;
					mix[0] = thrust - half;
					mix[1] = thrust - half;
					mix[2] = thrust + half;
					mix[3] = thrust + half;
					lowest = int'(qmm_pkg::START_LOWEST);
					for (int i = 0; i < 4; i++)
						if (mix[i] < lowest)
							lowest = mix[i];
					if (lowest <= 0) begin
						frame.fault = 1'b1;
						for (int i = 0; i < 4; i++)
							held[i] = qmm_pkg::MOTOR_W'(min_pwm);
					end else if (lowest < int'(min_pwm)) begin
						frame.rescaled = 1'b1;
						for (int i = 0; i < 4; i++)
							held[i] = clamp_compare(longint'(mix[i]) * longint'(min_pwm)
								/ longint'(lowest));
					end else begin
						for (int i = 0; i < 4; i++)
							held[i] = clamp_compare(longint'(mix[i]));
					end
				end
				default: ;
			endcase
			for (int i = 0; i < 4; i++)
				frame.motor[i] = held[i];
			expected_frames.push_back(frame);
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_frame(logic [63:0] data, logic [1:0] flags);
			motor_frame_t want;
			if (expected_frames.size() == 0) begin
				report("result transfer with no expected frame");
				return;
			end
			want = expected_frames.pop_front();
			for (int i = 0; i < 4; i++)
				if (data[qmm_pkg::MOTOR_W*i +: qmm_pkg::MOTOR_W] !== want.motor[i])
					report($sformatf("motor %0d got %0d expected %0d", i + 1,
						data[qmm_pkg::MOTOR_W*i +: qmm_pkg::MOTOR_W], want.motor[i]));
			if (flags[0] !== want.rescaled)
				report($sformatf("rescaled got %b expected %b", flags[0], want.rescaled));
			if (flags[1] !== want.fault)
				report($sformatf("fault got %b expected %b", flags[1], want.fault));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	mixer_scoreboard sb = new();
	int              burst_left = 0;
	bit              hold_off_req = 1'b0;

	quad_motor_mixer_rescale uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offers one tick and returns once it has been taken; bursts usually end in random gaps.
	task send_tick(input logic [qmm_pkg::SW_W-1:0] sw, input logic [qmm_pkg::STICK_W-1:0] stick,
			input logic [qmm_pkg::ROLL_W-1:0] roll);
		s_tuser <= sw;
		s_tdata <= {6'b0, roll, stick};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_tick(sw, stick, roll);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 25)) @(posedge clk);
			end
		end
	endtask

	task send_random_tick();
		int                          pick;
		logic [qmm_pkg::SW_W-1:0]    sw;
		logic [qmm_pkg::STICK_W-1:0] stick;
		logic [qmm_pkg::ROLL_W-1:0]  roll;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			sw = qmm_pkg::SW_DOWN;
		else if (pick == 6)
			sw = qmm_pkg::SW_UP;
		else if (pick == 7)
			sw = qmm_pkg::SW_MID;
		else
			sw = qmm_pkg::SW_HOLD;
		if ($urandom_range(0, 7) == 0)
			stick = qmm_pkg::STICK_W'($urandom_range(101, 127));
		else
			stick = qmm_pkg::STICK_W'($urandom_range(0, 100));
		if ($urandom_range(0, 7) == 0)
			roll = qmm_pkg::ROLL_W'($urandom_range(0, 2047));
		else
			roll = qmm_pkg::ROLL_W'($urandom_range(0, 2000) - 1000);
		send_tick(sw, stick, roll);
	endtask

	// Lets the pipeline drain so that the registers can be changed safely.
	task wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task apply_settings(input logic [qmm_pkg::CFG_DATA_W-1:0] idle,
			input logic [qmm_pkg::CFG_DATA_W-1:0] min_val,
			input logic [qmm_pkg::CFG_DATA_W-1:0] base,
			input logic [qmm_pkg::CFG_DATA_W-1:0] gain);
		logic [qmm_pkg::CFG_DATA_W-1:0] vals [4];
		logic [qmm_pkg::CFG_IDX_W-1:0]  regs [4];
		vals = '{idle, min_val, base, gain};
		regs = '{qmm_pkg::REG_IDLE_PWM, qmm_pkg::REG_MIN_PWM, qmm_pkg::REG_THRUST_BASE,
			qmm_pkg::REG_THRUST_GAIN};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.note_config(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_frame(m_tdata, m_tuser);

	initial begin
		int mode;
		int stretch;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			mode = $urandom_range(0, 2);
			stretch = $urandom_range(8, 60);
			repeat (stretch) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("quad_motor_mixer_rescale_tb failed");
		$finish;
	end

	initial begin
		logic [qmm_pkg::CFG_DATA_W-1:0] min_val;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle, hold, plain mix, rescale and odd roll halving.
		send_tick(qmm_pkg::SW_UP, 7'd0, 11'd0);
		send_tick(qmm_pkg::SW_MID, 7'd100, 11'd1000);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, 11'd0);
		send_tick(qmm_pkg::SW_HOLD, 7'd127, -11'sd1024);
		send_tick(qmm_pkg::SW_DOWN, 7'd100, 11'd1000);
		send_tick(qmm_pkg::SW_DOWN, 7'd100, -11'sd1000);
		send_tick(qmm_pkg::SW_DOWN, 7'd127, 11'd1023);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, 11'd600);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, -11'sd1);
		send_tick(qmm_pkg::SW_DOWN, 7'd5, 11'd3);
		send_tick(qmm_pkg::SW_DOWN, 7'd5, -11'sd3);
		send_tick(qmm_pkg::SW_HOLD, 7'd0, 11'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, -11'sd1024);
		wait_idle();

		// Zero thrust drives the lowest mixed value to zero or below.
		apply_settings(15'd1000, 15'd1100, 15'd0, 15'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, 11'd2);
		send_tick(qmm_pkg::SW_DOWN, 7'd127, 11'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, -11'sd1);
		wait_idle();

		// A lowest value of one with the largest threshold saturates the other pair.
		apply_settings(15'd32767, 15'd2047, 15'd512, 15'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, 11'd1023);
		send_tick(qmm_pkg::SW_UP, 7'd0, 11'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, -11'sd1023);
		wait_idle();

		// With a zero threshold no rescale can happen.
		apply_settings(15'd0, 15'd0, 15'd4095, 15'd63);
		send_tick(qmm_pkg::SW_DOWN, 7'd127, -11'sd1024);
		send_tick(qmm_pkg::SW_MID, 7'd0, 11'd0);
		send_tick(qmm_pkg::SW_DOWN, 7'd0, 11'd0);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(qmm_pkg::CFG_DATA_W'(qmm_pkg::RST_IDLE_PWM),
					qmm_pkg::CFG_DATA_W'(qmm_pkg::RST_MIN_PWM),
					qmm_pkg::CFG_DATA_W'(qmm_pkg::RST_THRUST_BASE),
					qmm_pkg::CFG_DATA_W'(qmm_pkg::RST_THRUST_GAIN));
				1: apply_settings(15'd32767, 15'd2000, 15'd600, 15'd4);
				2: apply_settings(15'd0, 15'd1, 15'd0, 15'd63);
				default: begin
					if ($urandom_range(0, 3) == 0)
						min_val = qmm_pkg::CFG_DATA_W'($urandom_range(0, 32767));
					else
						min_val = qmm_pkg::CFG_DATA_W'($urandom_range(0, 2047));
					apply_settings(qmm_pkg::CFG_DATA_W'($urandom_range(0, 32767)), min_val,
						qmm_pkg::CFG_DATA_W'($urandom_range(0, 4095)),
						qmm_pkg::CFG_DATA_W'($urandom_range(0, 63)));
				end
			endcase
			// One long output stall while ticks keep coming, so the input backs up.
			if (phase == 1)
				hold_off_req = 1'b1;
			repeat (TICKS_PER_PHASE) send_random_tick();
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("quad_motor_mixer_rescale_tb passed");
		else
			$display("quad_motor_mixer_rescale_tb failed");
		$finish;
	end

endmodule
